@@ rtl/core/ipdt_pkg.sv @@
// shared types and constants of the ir pulse-distance transmitter
package ipdt_pkg;

  localparam int MARK_W   = 16;
  localparam int SPACE_W  = 16;
  localparam int VAL_W    = 16;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // input commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_TBL   = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MARK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MARK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd4;

  // configuration reset values
  localparam logic [PERIOD_W-1:0] RST_PERIOD     = 10'd26;
  localparam logic [MARK_W-1:0]   RST_ONE_MARK   = 16'd560;
  localparam logic [SPACE_W-1:0]  RST_ONE_SPACE  = 16'd1690;
  localparam logic [MARK_W-1:0]   RST_ZERO_MARK  = 16'd560;
  localparam logic [SPACE_W-1:0]  RST_ZERO_SPACE = 16'd560;

  // segment kinds loaded into the output register
  localparam logic [2:0] KIND_BURST = 3'd0;
  localparam logic [2:0] KIND_PAUSE = 3'd1;
  localparam logic [2:0] KIND_SUBST = 3'd2;
  localparam logic [2:0] KIND_BAD   = 3'd3;
  localparam logic [2:0] KIND_DATA  = 3'd4;

  // divider operand selects
  localparam logic [1:0] DSEL_VAL   = 2'd0;
  localparam logic [1:0] DSEL_TMARK = 2'd1;
  localparam logic [1:0] DSEL_ONE   = 2'd2;
  localparam logic [1:0] DSEL_ZERO  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       tbl_wr;
    logic       tbl_rd;
    logic       div_start;
    logic [1:0] div_sel;
    logic       save_one;
    logic       save_zero;
    logic       out_load;
    logic [2:0] kind;
    logic       last;
    logic       shift;
  } ipdt_cmd_t;

  typedef struct packed {
    logic       div_busy;
    logic       out_free;
    logic [1:0] in_cmd;
    logic       in_start;
    logic       in_subst;
    logic       in_idx_ok;
  } ipdt_sts_t;

endpackage

@@ rtl/core/ipdt_if.sv @@
// valid/ready channel interfaces for input items and output segments
interface ipdt_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic                         section_start;
  logic [ipdt_pkg::VAL_W-1:0]   duration_or_symbol;
  logic [ipdt_pkg::SLOT_W-1:0]  table_slot;
  logic [ipdt_pkg::SPACE_W-1:0] table_space_us;

  modport source (
    output valid, command, section_start, duration_or_symbol, table_slot, table_space_us,
    input  ready
  );
  modport sink (
    input  valid, command, section_start, duration_or_symbol, table_slot, table_space_us,
    output ready
  );
endinterface

interface ipdt_out_if;
  logic                         valid;
  logic                         ready;
  logic [ipdt_pkg::MARK_W-1:0]  mark_cycles;
  logic [ipdt_pkg::SPACE_W-1:0] space_us;
  logic                         last_of_run;
  logic                         bad_symbol;

  modport source (
    output valid, mark_cycles, space_us, last_of_run, bad_symbol,
    input  ready
  );
  modport sink (
    input  valid, mark_cycles, space_us, last_of_run, bad_symbol,
    output ready
  );
endinterface

@@ rtl/core/ipdt_div.sv @@
// restoring divider, one quotient bit per cycle, microseconds to carrier periods
module ipdt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ipdt_pkg::MARK_W-1:0]   dividend,
  input  logic [ipdt_pkg::PERIOD_W-1:0] divisor,
  output logic                          busy,
  output logic [ipdt_pkg::MARK_W-1:0]   quotient
);

  localparam int QW = ipdt_pkg::MARK_W;
  localparam int DW = ipdt_pkg::PERIOD_W;
  localparam int CW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;

  assign sh   = {rem_r, quo_r[QW-1]};
  assign diff = sh - {1'b0, dv_r};
  assign ge   = sh >= {1'b0, dv_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      // a period of zero divides as one
      dv_nxt   = (divisor == '0) ? DW'(1) : divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/ipdt_dp.sv @@
// datapath: configuration registers, substitution table, divider and output register
module ipdt_dp #(
  parameter int SUBST_ENTRIES = 16,
  parameter int SUBST_BASE    = 500
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ipdt_pkg::ipdt_cmd_t             cmd,
  output ipdt_pkg::ipdt_sts_t             sts,
  input  logic                            cfg_we,
  input  logic [ipdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]                      in_command,
  input  logic                            in_section_start,
  input  logic [ipdt_pkg::VAL_W-1:0]      in_duration_or_symbol,
  input  logic [ipdt_pkg::SLOT_W-1:0]     in_table_slot,
  input  logic [ipdt_pkg::SPACE_W-1:0]    in_table_space_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ipdt_pkg::MARK_W-1:0]     out_mark_cycles,
  output logic [ipdt_pkg::SPACE_W-1:0]    out_space_us,
  output logic                            out_last_of_run,
  output logic                            out_bad_symbol
);

  localparam int MW    = ipdt_pkg::MARK_W;
  localparam int SW    = ipdt_pkg::SPACE_W;
  localparam int VW    = ipdt_pkg::VAL_W;
  localparam int PW    = ipdt_pkg::PERIOD_W;
  localparam int IDX_W = (SUBST_ENTRIES > 1) ? $clog2(SUBST_ENTRIES) : 1;
  localparam int EXT_W = 9;

  // configuration registers
  logic [PW-1:0] period_r;
  logic [MW-1:0] one_mark_r, zero_mark_r;
  logic [SW-1:0] one_space_r, zero_space_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= ipdt_pkg::RST_PERIOD;
      one_mark_r   <= ipdt_pkg::RST_ONE_MARK;
      one_space_r  <= ipdt_pkg::RST_ONE_SPACE;
      zero_mark_r  <= ipdt_pkg::RST_ZERO_MARK;
      zero_space_r <= ipdt_pkg::RST_ZERO_SPACE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipdt_pkg::CFG_PERIOD:     period_r     <= cfg_wdata[PW-1:0];
        ipdt_pkg::CFG_ONE_MARK:   one_mark_r   <= cfg_wdata[MW-1:0];
        ipdt_pkg::CFG_ONE_SPACE:  one_space_r  <= cfg_wdata[SW-1:0];
        ipdt_pkg::CFG_ZERO_MARK:  zero_mark_r  <= cfg_wdata[MW-1:0];
        ipdt_pkg::CFG_ZERO_SPACE: zero_space_r <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // substitution index and slot checks on the incoming word
  logic [VW-1:0]    sub_idx;
  logic             in_subst, in_idx_ok, slot_ok;
  logic [EXT_W-1:0] slot_ext;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  assign in_subst  = in_duration_or_symbol > VW'(SUBST_BASE);
  assign sub_idx   = in_duration_or_symbol - VW'(SUBST_BASE) - VW'(1);
  assign in_idx_ok = sub_idx < VW'(SUBST_ENTRIES);
  assign slot_ext  = EXT_W'(in_table_slot);
  assign slot_ok   = slot_ext < EXT_W'(SUBST_ENTRIES);
  assign rd_addr   = sub_idx[IDX_W-1:0];
  assign wr_addr   = slot_ext[IDX_W-1:0];

  // table memory, entries not yet written read as zero
  logic [MW+SW-1:0]         tbl_mem [SUBST_ENTRIES];
  logic [SUBST_ENTRIES-1:0] vld_r;
  logic [MW+SW-1:0]         rd_data_r;
  logic                     rd_vld_r;
  logic [MW-1:0]            t_mark;
  logic [SW-1:0]            t_space;

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && slot_ok) begin
      tbl_mem[wr_addr] <= {in_duration_or_symbol, in_table_space_us};
    end
    if (cmd.tbl_rd) begin
      rd_data_r <= tbl_mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.tbl_wr && slot_ok) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign t_mark  = rd_vld_r ? rd_data_r[MW+SW-1:SW] : '0;
  assign t_space = rd_vld_r ? rd_data_r[SW-1:0] : '0;

  // latched item
  logic [VW-1:0] val_r;
  logic [7:0]    byte_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_duration_or_symbol;
      byte_r <= in_duration_or_symbol[7:0];
    end else if (cmd.shift) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
  end

  // divider and saved bit quotients
  logic [MW-1:0] div_a, quo;
  logic          div_busy;
  logic [MW-1:0] q_one_r, q_zero_r;

  always_comb begin
    case (cmd.div_sel)
      ipdt_pkg::DSEL_VAL:   div_a = in_duration_or_symbol;
      ipdt_pkg::DSEL_TMARK: div_a = t_mark;
      ipdt_pkg::DSEL_ONE:   div_a = one_mark_r;
      default:              div_a = zero_mark_r;
    endcase
  end

  ipdt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (period_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.save_one) begin
      q_one_r <= quo;
    end
    if (cmd.save_zero) begin
      q_zero_r <= quo;
    end
  end

  // output register
  logic          out_valid_r;
  logic [MW-1:0] mark_r, mark_nxt;
  logic [SW-1:0] space_r, space_nxt;
  logic          last_r, bad_r, bad_nxt;

  always_comb begin
    mark_nxt  = '0;
    space_nxt = '0;
    bad_nxt   = 1'b0;
    unique case (cmd.kind)
      ipdt_pkg::KIND_BURST: mark_nxt = quo;
      ipdt_pkg::KIND_PAUSE: space_nxt = val_r;
      ipdt_pkg::KIND_SUBST: begin
        mark_nxt  = quo;
        space_nxt = t_space;
      end
      ipdt_pkg::KIND_BAD: bad_nxt = 1'b1;
      ipdt_pkg::KIND_DATA: begin
        mark_nxt  = byte_r[7] ? q_one_r : q_zero_r;
        space_nxt = byte_r[7] ? one_space_r : zero_space_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mark_r  <= mark_nxt;
      space_r <= space_nxt;
      last_r  <= cmd.last;
      bad_r   <= bad_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mark_cycles = mark_r;
  assign out_space_us    = space_r;
  assign out_last_of_run = last_r;
  assign out_bad_symbol  = bad_r;

  assign sts.div_busy  = div_busy;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.in_cmd    = in_command;
  assign sts.in_start  = in_section_start;
  assign sts.in_subst  = in_subst;
  assign sts.in_idx_ok = in_idx_ok;

endmodule

@@ rtl/core/ipdt_ctrl.sv @@
// controller: sequences divisions and segment pushes for each accepted framing or data word
module ipdt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipdt_pkg::ipdt_sts_t sts,
  output ipdt_pkg::ipdt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_DIV1 = 3'd4;
  localparam logic [2:0] S_DIV0 = 3'd5;
  localparam logic [2:0] S_BITS = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic       parity_r, parity_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    bit_cnt_nxt = bit_cnt_r;
    parity_nxt  = parity_r;
    cmd         = '0;
    cmd.kind    = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (sts.in_cmd)
            ipdt_pkg::CMD_FRAME: begin
              // section start forces a burst and sets parity; other framing words flip parity
              parity_nxt = ~(parity_r & ~sts.in_start);
              if (sts.in_start || !parity_r) begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ipdt_pkg::DSEL_VAL;
                kind_nxt      = ipdt_pkg::KIND_BURST;
                state_nxt     = S_DIV;
              end else begin
                kind_nxt  = ipdt_pkg::KIND_PAUSE;
                state_nxt = S_PUSH;
              end
            end
            ipdt_pkg::CMD_DATA: begin
              if (sts.in_subst && sts.in_idx_ok) begin
                cmd.tbl_rd = 1'b1;
                kind_nxt   = ipdt_pkg::KIND_SUBST;
                state_nxt  = S_LOOK;
              end else if (sts.in_subst) begin
                kind_nxt  = ipdt_pkg::KIND_BAD;
                state_nxt = S_PUSH;
              end else begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ipdt_pkg::DSEL_ONE;
                state_nxt     = S_DIV1;
              end
            end
            ipdt_pkg::CMD_TBL: cmd.tbl_wr = 1'b1;
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ipdt_pkg::DSEL_TMARK;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DIV1: begin
        if (!sts.div_busy) begin
          cmd.save_one  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = ipdt_pkg::DSEL_ZERO;
          state_nxt     = S_DIV0;
        end
      end
      S_DIV0: begin
        if (!sts.div_busy) begin
          cmd.save_zero = 1'b1;
          bit_cnt_nxt   = '0;
          state_nxt     = S_BITS;
        end
      end
      S_BITS: begin
        cmd.kind = ipdt_pkg::KIND_DATA;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.shift    = 1'b1;
          cmd.last     = (bit_cnt_r == 3'd7);
          bit_cnt_nxt  = bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      kind_r    <= ipdt_pkg::KIND_BURST;
      bit_cnt_r <= '0;
      parity_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      kind_r    <= kind_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      parity_r  <= parity_nxt;
    end
  end

endmodule

@@ rtl/core/ir_pulse_distance_transmitter.sv @@
// Infrared pulse-distance transmitter: turns framing words, data symbols and table writes into
// burst/space segments. A framing pause needs no division; framing bursts, substitutions and
// data bytes wait on the shared restoring divider, which produces one quotient bit per cycle
// (two divisions per data byte, one per burst or substitution). A table write or an unused
// command gives no segment and leaves the controller idle. The next word is taken as soon as
// the last segment of the current one sits in the output register. The substitution table
// needs no clearing pass after reset.
module ir_pulse_distance_transmitter #(
  parameter int SUBST_ENTRIES = 16,
  parameter int SUBST_BASE    = 500
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ipdt_in_if.sink                         in_ch,
  ipdt_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ipdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipdt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ipdt_pkg::ipdt_cmd_t cmd;
  ipdt_pkg::ipdt_sts_t sts;
  logic                ready;

  assign in_ch.ready = ready;

  ipdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipdt_dp #(
    .SUBST_ENTRIES (SUBST_ENTRIES),
    .SUBST_BASE    (SUBST_BASE)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_command            (in_ch.command),
    .in_section_start      (in_ch.section_start),
    .in_duration_or_symbol (in_ch.duration_or_symbol),
    .in_table_slot         (in_ch.table_slot),
    .in_table_space_us     (in_ch.table_space_us),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_mark_cycles       (out_ch.mark_cycles),
    .out_space_us          (out_ch.space_us),
    .out_last_of_run       (out_ch.last_of_run),
    .out_bad_symbol        (out_ch.bad_symbol)
  );

endmodule

@@ rtl/core/ipdt_checker.sv @@
// port-level assertions for the ir pulse-distance transmitter, bound to the top level
module ipdt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    in_command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ipdt_pkg::MARK_W-1:0]   out_mark_cycles,
  input logic [ipdt_pkg::SPACE_W-1:0]  out_space_us,
  input logic                          out_last_of_run,
  input logic                          out_bad_symbol
);

  // a word waiting at the output is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // error segments are empty and close the run
  a_bad_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_symbol |->
      out_last_of_run && out_mark_cycles == '0 && out_space_us == '0)
    else $error("bad symbol segment malformed");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // table writes and unused commands give no segment
  a_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
      (in_command == ipdt_pkg::CMD_TBL || in_command == ipdt_pkg::CMD_NONE)
      |=> !out_valid)
    else $error("segment produced by a silent command");

endmodule

bind ir_pulse_distance_transmitter ipdt_checker u_ipdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_mark_cycles (out_ch.mark_cycles),
  .out_space_us    (out_ch.space_us),
  .out_last_of_run (out_ch.last_of_run),
  .out_bad_symbol  (out_ch.bad_symbol)
);
